>>> hw/rtl/pdc_pkg.sv
// Shared types and constants for the PID drive controller.
package pdc_pkg;

  localparam int ERR_W   = 17;
  localparam int GAIN_W  = 24;
  localparam int INTEG_W = 25;
  localparam int DERIV_W = 18;
  localparam int PROD_W  = GAIN_W + INTEG_W;
  localparam int ACC_W   = 50;
  localparam int SAT_W   = 21;

  localparam logic [1:0] OP_SENSOR      = 2'd0;
  localparam logic [1:0] OP_EXTERNAL    = 2'd1;
  localparam logic [1:0] OP_TABLE_WRITE = 2'd2;

  localparam logic [2:0] CFG_GAIN_P         = 3'd0;
  localparam logic [2:0] CFG_GAIN_I         = 3'd1;
  localparam logic [2:0] CFG_GAIN_D         = 3'd2;
  localparam logic [2:0] CFG_DRIVE_BIAS     = 3'd3;
  localparam logic [2:0] CFG_WINDUP_LIMIT   = 3'd4;
  localparam logic [2:0] CFG_DEADBAND       = 3'd5;
  localparam logic [2:0] CFG_REVERSE_SENSOR = 3'd6;
  localparam logic [2:0] CFG_LOOP_ENABLED   = 3'd7;

  localparam logic signed [ERR_W-1:0] ERR_MAX        = 17'sd65535;
  localparam logic [11:0]             ANALOG_FULL    = 12'd4095;
  localparam logic [15:0]             DEADBAND_RESET = 16'd10;
  localparam logic signed [ACC_W-1:0] ONE_Q20        = 50'sd1048576;
  localparam logic [SAT_W-1:0]        SAT_ONE        = 21'h100000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERROR,
    S_INTEG,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_ACC,
    S_SAT,
    S_SCALE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic mul_en;
    logic acc_clear;
    logic acc_add;
  } mac_ctrl_t;

endpackage

>>> hw/rtl/pdc_table_ram.sv
// Linearization table memory: one write port, one registered read port.
module pdc_table_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/pdc_mac.sv
// Shared signed multiplier with a registered product and the drive accumulator.
module pdc_mac import pdc_pkg::*; (
  input  logic                     clk,
  input  mac_ctrl_t                ctrl,
  input  logic signed [GAIN_W-1:0] op_a,
  input  logic signed [INTEG_W-1:0] op_b,
  input  logic signed [GAIN_W-1:0] bias,
  output logic signed [ACC_W-1:0]  acc
);

  logic signed [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= PROD_W'(op_a) * PROD_W'(op_b);
    end
  end

  // The bias seeds the sum while the first product is formed.
  always_ff @(posedge clk) begin
    if (ctrl.acc_clear) begin
      acc <= ACC_W'(bias);
    end else if (ctrl.acc_add) begin
      acc <= acc + ACC_W'(prod);
    end
  end

endmodule

>>> hw/rtl/pid_drive_controller_top.sv
// Top level of the PID drive controller with deadband, anti-windup and linearization.
// A control step runs the sequencer through its error and integral states, a multiply
// state for each of the three gain products on one shared 24x25 multiplier, and the
// accumulate, saturate and scale states; the scale state reads the linearization table,
// whose read data is registered, and the done state loads the output register. The next
// item can be accepted once the sequencer is back in idle. A table write, an unknown
// operation or a step while the loop is disabled goes from the error state straight to
// the done state. A stalled result holds the sequencer in its last state until the
// output register is free. One item is in work at a time; the next item is accepted
// while the previous result still waits in the output register. The table has no reset:
// every entry that a step can read must be written before use.
module pid_drive_controller_top import pdc_pkg::*; #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic signed [15:0] sensor_sample,
  input  logic               sensor_is_analog,
  input  logic signed [15:0] setpoint,
  input  logic signed [16:0] outside_error,
  input  logic [6:0]         table_index,
  input  logic [7:0]         table_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [8:0]  motor_command,
  output logic signed [7:0]  scaled_drive,
  output logic signed [16:0] used_error,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  localparam int         TAW    = $clog2(TABLE_DEPTH);
  localparam logic [8:0] DEPTH9 = 9'(TABLE_DEPTH);
  localparam logic [8:0] LAST9  = 9'(TABLE_DEPTH - 1);

  // Configuration registers.
  logic signed [GAIN_W-1:0] gain_p, gain_i, gain_d, drive_bias;
  logic [23:0]              windup_limit;
  logic [15:0]              deadband;
  logic                     reverse_sensor, loop_enabled;

  state_t state, state_next;

  // Captured transaction.
  logic [1:0]         op_q;
  logic signed [15:0] sample_q, setpoint_q;
  logic               analog_q;
  logic signed [16:0] oerr_q;
  logic [6:0]         tidx_q;
  logic [7:0]         tval_q;

  logic signed [ERR_W-1:0]   err_q, prev_err;
  logic signed [INTEG_W-1:0] integral;
  logic signed [DERIV_W-1:0] deriv_q;
  logic [SAT_W-1:0]          sat_mag;
  logic                      sat_neg;
  logic signed [7:0]         scaled_q;

  logic signed [17:0]        sens_x;
  logic signed [18:0]        raw_err;
  logic signed [ERR_W-1:0]   clip_err, err_db;
  logic [15:0]               err_mag;
  logic signed [INTEG_W:0]   integ_sum, integ_lim;
  logic signed [INTEG_W-1:0] integ_next;
  logic [SAT_W-1:0]          sat_mag_next;
  logic [27:0]               prod127;
  logic [6:0]                mag7;
  logic [8:0]                idx9;
  logic signed [7:0]         scaled_next;

  logic                      is_step, out_free;
  mac_ctrl_t                 mac_ctrl;
  logic signed [GAIN_W-1:0]  mul_a;
  logic signed [INTEG_W-1:0] mul_b;
  logic signed [ACC_W-1:0]   acc;
  logic                      tbl_wr_en, tbl_rd_en;
  logic [TAW-1:0]            tbl_wr_addr, tbl_rd_addr;
  logic [7:0]                tbl_rd_data;

  assign cfg_ready = !rst;
  assign is_step   = (op_q == OP_SENSOR) || (op_q == OP_EXTERNAL);
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      drive_bias     <= '0;
      windup_limit   <= '0;
      deadband       <= DEADBAND_RESET;
      reverse_sensor <= 1'b0;
      loop_enabled   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GAIN_P:         gain_p         <= $signed(cfg_data);
        CFG_GAIN_I:         gain_i         <= $signed(cfg_data);
        CFG_GAIN_D:         gain_d         <= $signed(cfg_data);
        CFG_DRIVE_BIAS:     drive_bias     <= $signed(cfg_data);
        CFG_WINDUP_LIMIT:   windup_limit   <= cfg_data;
        CFG_DEADBAND:       deadband       <= cfg_data[15:0];
        CFG_REVERSE_SENSOR: reverse_sensor <= cfg_data[0];
        CFG_LOOP_ENABLED:   loop_enabled   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Error path: optional sensor reversal, saturation to the error range, deadband.
  always_comb begin
    sens_x = 18'(sample_q);
    if (reverse_sensor) begin
      sens_x = analog_q ? ($signed({6'b0, ANALOG_FULL}) - sens_x) : -sens_x;
    end
    if (op_q == OP_SENSOR) begin
      raw_err = 19'(setpoint_q) - 19'(sens_x);
    end else begin
      raw_err = 19'(oerr_q);
    end
    if (raw_err > 19'(ERR_MAX)) begin
      clip_err = ERR_MAX;
    end else if (raw_err < -19'(ERR_MAX)) begin
      clip_err = -ERR_MAX;
    end else begin
      clip_err = ERR_W'(raw_err);
    end
    err_mag = clip_err[ERR_W-1] ? 16'(-clip_err) : 16'(clip_err);
    err_db  = (err_mag < deadband) ? '0 : clip_err;
  end

  // Integral accumulation with the windup clamp; cleared while the integral gain is zero.
  always_comb begin
    integ_sum = (INTEG_W+1)'(integral) + (INTEG_W+1)'(err_q);
    integ_lim = $signed({2'b0, windup_limit});
    if (gain_i == '0) begin
      integ_next = '0;
    end else if (integ_sum > integ_lim) begin
      integ_next = INTEG_W'(integ_lim);
    end else if (integ_sum < -integ_lim) begin
      integ_next = INTEG_W'(-integ_lim);
    end else begin
      integ_next = INTEG_W'(integ_sum);
    end
  end

  // Saturation to +/-1.0 and scaling by 127 with truncation toward zero on the magnitude.
  always_comb begin
    if (acc > ONE_Q20 || acc < -ONE_Q20) begin
      sat_mag_next = SAT_ONE;
    end else if (acc[ACC_W-1]) begin
      sat_mag_next = SAT_W'(-acc);
    end else begin
      sat_mag_next = SAT_W'(acc);
    end
    prod127     = {sat_mag, 7'b0} - 28'(sat_mag);
    mag7        = prod127[26:20];
    idx9        = {2'b0, mag7};
    scaled_next = sat_neg ? -$signed({1'b0, mag7}) : $signed({1'b0, mag7});
    tbl_rd_addr = (idx9 >= DEPTH9) ? TAW'(LAST9) : TAW'(idx9);
    tbl_wr_addr = TAW'({2'b0, tidx_q});
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_ERROR;
      S_ERROR: state_next = (is_step && loop_enabled) ? S_INTEG : S_DONE;
      S_INTEG: state_next = S_MUL_P;
      S_MUL_P: state_next = S_MUL_I;
      S_MUL_I: state_next = S_MUL_D;
      S_MUL_D: state_next = S_ACC;
      S_ACC:   state_next = S_SAT;
      S_SAT:   state_next = S_SCALE;
      S_SCALE: state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = rst || (state != S_IDLE);
    mac_ctrl  = '0;
    mul_a     = gain_p;
    mul_b     = INTEG_W'(err_q);
    tbl_wr_en = 1'b0;
    tbl_rd_en = 1'b0;
    case (state)
      S_ERROR: begin
        tbl_wr_en = (op_q == OP_TABLE_WRITE) && ({2'b0, tidx_q} < DEPTH9);
      end
      S_MUL_P: begin
        mac_ctrl.mul_en    = 1'b1;
        mac_ctrl.acc_clear = 1'b1;
      end
      S_MUL_I: begin
        mac_ctrl.mul_en  = 1'b1;
        mac_ctrl.acc_add = 1'b1;
        mul_a            = gain_i;
        mul_b            = integral;
      end
      S_MUL_D: begin
        mac_ctrl.mul_en  = 1'b1;
        mac_ctrl.acc_add = 1'b1;
        mul_a            = gain_d;
        mul_b            = INTEG_W'(deriv_q);
      end
      S_ACC: begin
        mac_ctrl.acc_add = 1'b1;
      end
      S_SCALE: begin
        tbl_rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      integral <= '0;
      prev_err <= '0;
    end else if (state == S_ERROR && is_step && !loop_enabled) begin
      integral <= '0;
      prev_err <= '0;
    end else if (state == S_INTEG) begin
      integral <= integ_next;
      prev_err <= err_q;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_q       <= operation;
      sample_q   <= sensor_sample;
      analog_q   <= sensor_is_analog;
      setpoint_q <= setpoint;
      oerr_q     <= outside_error;
      tidx_q     <= table_index;
      tval_q     <= table_value;
    end
    if (state == S_ERROR) begin
      err_q    <= (is_step && loop_enabled) ? err_db : '0;
      scaled_q <= '0;
    end
    if (state == S_INTEG) begin
      deriv_q <= DERIV_W'(err_q) - DERIV_W'(prev_err);
    end
    if (state == S_SAT) begin
      sat_mag <= sat_mag_next;
      sat_neg <= acc[ACC_W-1];
    end
    if (state == S_SCALE) begin
      scaled_q <= scaled_next;
    end
  end

  // Output register; a zero drive always gives a zero command.
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      scaled_drive <= scaled_q;
      used_error   <= err_q;
      if (scaled_q == '0) begin
        motor_command <= '0;
      end else if (scaled_q[7]) begin
        motor_command <= -$signed({1'b0, tbl_rd_data});
      end else begin
        motor_command <= $signed({1'b0, tbl_rd_data});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  pdc_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (mul_a),
    .op_b (mul_b),
    .bias (drive_bias),
    .acc  (acc)
  );

  pdc_table_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (TAW)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tval_q),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  a_table_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(tbl_wr_en && tbl_rd_en))
    else $error("table written and read in the same cycle");

  a_integral_within_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_INTEG) |=> ((INTEG_W+1)'(integral) <= integ_lim &&
                            (INTEG_W+1)'(integral) >= -integ_lim))
    else $error("integral outside the windup limit");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result presented without finishing a transaction");

  a_disabled_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_ERROR && !loop_enabled) |=> (err_q == '0 && scaled_q == '0))
    else $error("disabled step produced a nonzero result");

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the PID drive controller: directed and random control steps.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pdc_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         TABLE_SIZE  = 128;
  localparam longint     DRIVE_SCALE = 127;
  localparam longint     Q20_ONE     = 64'sd1048576;
  localparam longint     ERR_LIMIT   = 64'sd65535;

  typedef struct {
    logic [1:0]         op;
    logic signed [15:0] sample;
    logic               analog;
    logic signed [15:0] target;
    logic signed [16:0] ext_err;
    logic [6:0]         tidx;
    logic [7:0]         tval;
  } ctrl_item_t;

  typedef struct {
    logic signed [8:0]  cmd;
    logic signed [7:0]  drive;
    logic signed [16:0] err;
  } ctrl_result_t;

  typedef struct {
    logic signed [23:0] kp;
    logic signed [23:0] ki;
    logic signed [23:0] kd;
    logic signed [23:0] bias;
    logic [23:0]        windup;
    logic [15:0]        deadband;
    logic               reverse;
    logic               enable;
  } ctrl_cfg_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         operation = OP_SENSOR;
  logic signed [15:0] sensor_sample = '0;
  logic               sensor_is_analog = 1'b0;
  logic signed [15:0] setpoint = '0;
  logic signed [16:0] outside_error = '0;
  logic [6:0]         table_index = '0;
  logic [7:0]         table_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [8:0]  motor_command;
  logic signed [7:0]  scaled_drive;
  logic signed [16:0] used_error;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [23:0]        cfg_data = '0;

  // Mirror of the controller: registers, accumulated state and the drive table.
  ctrl_cfg_t    mir = '{kp: '0, ki: '0, kd: '0, bias: '0, windup: '0,
                        deadband: DEADBAND_RESET, reverse: 1'b0, enable: 1'b1};
  longint       integ_sum = 0;
  longint       last_err = 0;
  logic [7:0]   lin_table [TABLE_SIZE];
  ctrl_result_t pending_results [$];

  int mismatches = 0;
  int max_in_gap = 15;
  int max_out_stall = 15;
  int hold_request = 0;

  pid_drive_controller_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .sensor_sample(sensor_sample),
    .sensor_is_analog(sensor_is_analog), .setpoint(setpoint),
    .outside_error(outside_error), .table_index(table_index),
    .table_value(table_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .motor_command(motor_command), .scaled_drive(scaled_drive),
    .used_error(used_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint clamp_mag(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void apply_cfg(logic [2:0] idx, logic [23:0] data);
    case (idx)
      CFG_GAIN_P:         mir.kp = data;
      CFG_GAIN_I:         mir.ki = data;
      CFG_GAIN_D:         mir.kd = data;
      CFG_DRIVE_BIAS:     mir.bias = data;
      CFG_WINDUP_LIMIT:   mir.windup = data;
      CFG_DEADBAND:       mir.deadband = data[15:0];
      CFG_REVERSE_SENSOR: mir.reverse = data[0];
      CFG_LOOP_ENABLED:   mir.enable = data[0];
      default: ;
    endcase
  endfunction

  // Advances the mirrored controller by one step and returns its outputs.
  function automatic ctrl_result_t predict_step(ctrl_item_t it);
    longint e, s, deriv, drive, sc, mag;
    ctrl_result_t r;
    r.cmd = '0;
    r.drive = '0;
    r.err = '0;
    if (it.op == OP_TABLE_WRITE) begin
      lin_table[it.tidx] = it.tval;
    end else if (it.op == OP_SENSOR || it.op == OP_EXTERNAL) begin
      if (!mir.enable) begin
        integ_sum = 0;
        last_err = 0;
      end else begin
        if (it.op == OP_SENSOR) begin
          s = longint'(it.sample);
          if (mir.reverse) s = it.analog ? longint'(ANALOG_FULL) - s : -s;
          e = clamp_mag(longint'(it.target) - s, ERR_LIMIT);
        end else begin
          e = clamp_mag(longint'(it.ext_err), ERR_LIMIT);
        end
        if ((e < 0 ? -e : e) < longint'(mir.deadband)) e = 0;
        if (mir.ki != 0) integ_sum = clamp_mag(integ_sum + e, longint'(mir.windup));
        else integ_sum = 0;
        deriv = e - last_err;
        last_err = e;
        drive = longint'(mir.kp) * e + longint'(mir.ki) * integ_sum
              + longint'(mir.kd) * deriv + longint'(mir.bias);
        drive = clamp_mag(drive, Q20_ONE);
        // Signed division truncates toward zero.
        sc = (drive * DRIVE_SCALE) / Q20_ONE;
        mag = sc < 0 ? -sc : sc;
        if (sc > 0) r.cmd = $signed({1'b0, lin_table[7'(mag)]});
        else if (sc < 0) r.cmd = -$signed({1'b0, lin_table[7'(mag)]});
        r.drive = 8'(sc);
        r.err = 17'(e);
      end
    end
    return r;
  endfunction

  function automatic ctrl_item_t noise_item();
    ctrl_item_t it;
    it.op = 2'($urandom);
    it.sample = 16'($urandom);
    it.analog = 1'($urandom);
    it.target = 16'($urandom);
    it.ext_err = 17'($urandom);
    it.tidx = 7'($urandom);
    it.tval = 8'($urandom);
    return it;
  endfunction

  function automatic ctrl_item_t ext_step(int e);
    ctrl_item_t it;
    it = noise_item();
    it.op = OP_EXTERNAL;
    it.ext_err = 17'(e);
    return it;
  endfunction

  function automatic ctrl_item_t sensor_step(int sample, bit analog, int target);
    ctrl_item_t it;
    it = noise_item();
    it.op = OP_SENSOR;
    it.sample = 16'(sample);
    it.analog = analog;
    it.target = 16'(target);
    return it;
  endfunction

  function automatic ctrl_item_t random_item();
    ctrl_item_t it;
    int pick;
    it = noise_item();
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      it.op = OP_SENSOR;
      if (it.analog) begin
        it.sample = 16'($urandom_range(0, 4095));
        it.target = 16'($urandom_range(0, 4095));
      end else begin
        it.sample = 16'(int'($urandom_range(0, 4000)) - 2000);
        it.target = 16'(int'($urandom_range(0, 4000)) - 2000);
      end
    end else if (pick < 70) begin
      it.op = OP_EXTERNAL;
      it.ext_err = 17'(int'($urandom_range(0, 6000)) - 3000);
    end else if (pick < 82) begin
      // Full-range fields can drive the error into its limits.
      it.op = ($urandom_range(0, 1) != 0) ? OP_SENSOR : OP_EXTERNAL;
    end else if (pick < 94) begin
      it.op = OP_TABLE_WRITE;
    end else begin
      it.op = OP_UNUSED;
    end
    return it;
  endfunction

  function automatic ctrl_cfg_t make_cfg(int kp, int ki, int kd, int bias, int windup,
                                         int deadband, bit reverse, bit enable);
    ctrl_cfg_t c;
    c.kp = 24'(kp);
    c.ki = 24'(ki);
    c.kd = 24'(kd);
    c.bias = 24'(bias);
    c.windup = 24'(windup);
    c.deadband = 16'(deadband);
    c.reverse = reverse;
    c.enable = enable;
    return c;
  endfunction

  task automatic send_item(ctrl_item_t it);
    int gap;
    gap = $urandom_range(0, max_in_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    operation        <= it.op;
    sensor_sample    <= it.sample;
    sensor_is_analog <= it.analog;
    setpoint         <= it.target;
    outside_error    <= it.ext_err;
    table_index      <= it.tidx;
    table_value      <= it.tval;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_step(it));
  endtask

  // Stops offering items and waits until every expected result has come back.
  task automatic settle_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_cfg(idx, data);
  endtask

  task automatic load_config(ctrl_cfg_t c);
    settle_results();
    cfg_write(CFG_GAIN_P, c.kp);
    cfg_write(CFG_GAIN_I, c.ki);
    cfg_write(CFG_GAIN_D, c.kd);
    cfg_write(CFG_DRIVE_BIAS, c.bias);
    cfg_write(CFG_WINDUP_LIMIT, c.windup);
    cfg_write(CFG_DEADBAND, {8'd0, c.deadband});
    cfg_write(CFG_REVERSE_SENSOR, {23'd0, c.reverse});
    cfg_write(CFG_LOOP_ENABLED, {23'd0, c.enable});
    cfg_valid <= 1'b0;
  endtask

  // Every entry is written before any step can read it.
  task automatic load_table();
    ctrl_item_t it;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      it = noise_item();
      it.op = OP_TABLE_WRITE;
      it.tidx = 7'(i);
      send_item(it);
    end
  endtask

  task automatic test_error_limits();
    ctrl_item_t it;
    load_config(make_cfg(16, 0, 0, 0, 0, 10, 1'b0, 1'b1));
    send_item(sensor_step(32767, 1'b0, -32768));
    send_item(sensor_step(-32768, 1'b1, 32767));
    send_item(ext_step(-65536));
    send_item(ext_step(65535));
    send_item(ext_step(9));
    send_item(ext_step(-10));
    send_item(ext_step(0));
    it = noise_item();
    it.op = OP_TABLE_WRITE;
    it.tidx = 7'd127;
    it.tval = 8'd255;
    send_item(it);
    it = noise_item();
    it.op = OP_UNUSED;
    send_item(it);
    send_item(ext_step(-65535));
  endtask

  task automatic test_sensor_reversal();
    load_config(make_cfg(16, 0, 0, 0, 0, 10, 1'b1, 1'b1));
    send_item(sensor_step(0, 1'b1, 4095));
    send_item(sensor_step(4095, 1'b1, 0));
    send_item(sensor_step(-32768, 1'b1, 32767));
    send_item(sensor_step(-32768, 1'b0, 32767));
    send_item(sensor_step(32767, 1'b0, 32767));
  endtask

  task automatic test_integral_windup();
    load_config(make_cfg(0, 30, 0, 0, 30000, 0, 1'b0, 1'b1));
    repeat (3) send_item(ext_step(12000));
    send_item(ext_step(-40000));
    send_item(ext_step(-40000));
    // With the integral gain at zero the accumulator is cleared.
    load_config(make_cfg(16, 0, 0, 0, 30000, 0, 1'b0, 1'b1));
    send_item(ext_step(500));
  endtask

  task automatic test_loop_disable();
    ctrl_item_t it;
    load_config(make_cfg(16, 40, 2000, 0, 5000, 10, 1'b0, 1'b0));
    send_item(sensor_step(100, 1'b1, 3000));
    send_item(ext_step(-4000));
    load_config(make_cfg(16, 40, 2000, 0, 5000, 10, 1'b0, 1'b1));
    send_item(ext_step(100));
    it = noise_item();
    it.op = OP_UNUSED;
    send_item(it);
  endtask

  task automatic test_random_sweep(ctrl_cfg_t c, int count, int gap_max, int stall_max);
    load_config(c);
    max_in_gap = gap_max;
    max_out_stall = stall_max;
    for (int k = 0; k < count; k++) begin
      if (k % 60 == 59) settle_results();
      send_item(random_item());
    end
    max_in_gap = 15;
    max_out_stall = 15;
  endtask

  // The receiver holds off while items keep coming, so the input must stall.
  task automatic test_output_backpressure();
    load_config(make_cfg(300, 40, 150, 0, 20000, 10, 1'b0, 1'b1));
    max_in_gap = 0;
    hold_request = 250;
    repeat (40) send_item(random_item());
    max_in_gap = 15;
  endtask

  initial begin : result_sink
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
      end else begin
        n = $urandom_range(0, max_out_stall);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    ctrl_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no step outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (motor_command !== want.cmd) begin
          $error("motor_command: expected %0d, got %0d", want.cmd, motor_command);
          mismatches++;
        end
        if (scaled_drive !== want.drive) begin
          $error("scaled_drive: expected %0d, got %0d", want.drive, scaled_drive);
          mismatches++;
        end
        if (used_error !== want.err) begin
          $error("used_error: expected %0d, got %0d", want.err, used_error);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    load_table();
    test_error_limits();
    test_sensor_reversal();
    test_integral_windup();
    test_loop_disable();
    test_random_sweep(make_cfg(300, 40, 150, 0, 20000, 10, 1'b0, 1'b1), 100, 15, 15);
    test_random_sweep(make_cfg(-250, 0, -400, 100000, 1000, 50, 1'b1, 1'b1), 80, 15, 15);
    test_random_sweep(make_cfg(8388607, -8388608, -8388608, 8388607, 16777215, 0,
                               1'b1, 1'b1), 120, 15, 15);
    test_random_sweep(make_cfg(-8388608, 8388607, 8388607, -8388608, 0, 65535,
                               1'b0, 1'b1), 40, 15, 15);
    test_random_sweep(make_cfg(20, 5, 10, -50000, 300000, 5, 1'b0, 1'b1), 140, 0, 0);
    test_random_sweep(make_cfg(300, 40, 150, 0, 20000, 10, 1'b1, 1'b0), 30, 15, 15);
    test_output_backpressure();
    settle_results();
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/pdc_pkg.sv
hw/rtl/pdc_table_ram.sv
hw/rtl/pdc_mac.sv
hw/rtl/pid_drive_controller_top.sv
bench/testbench.sv
